// File: design/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// utf8v_pkg: shared types for the UTF-8 validator
// Holds the decoder state record that the top level stores and the step
// logic updates.
// ----------------------------------------------------------------------------
package utf8v_pkg;

	localparam int unsigned CpWidth = 21;

	typedef struct packed {
		logic [1:0]         bytes_left;
		logic [2:0]         seq_length;
		logic [CpWidth-1:0] code_point;
		logic               failed;
	} utf8v_state_t;

	localparam utf8v_state_t StateReset = '{
		bytes_left: 2'd0,
		seq_length: 3'd0,
		code_point: '0,
		failed:     1'b0
	};

endpackage

// File: design/utf8v_step.sv
// ----------------------------------------------------------------------------
// utf8v_step: next-state logic for one byte of the string
// Decodes a lead or continuation byte, accumulates the code point and checks
// for overlong forms, surrogates, out-of-range values and combining marks.
// ----------------------------------------------------------------------------
module utf8v_step (
	input  utf8v_pkg::utf8v_state_t cur,
	input  logic [7:0]              text_byte,
	input  logic                    has_byte,
	input  logic                    last,
	output utf8v_pkg::utf8v_state_t nxt,
	output logic                    verdict
);
	import utf8v_pkg::*;

	localparam logic [CpWidth-1:0] Mark0Lo = 21'h000300;
	localparam logic [CpWidth-1:0] Mark0Hi = 21'h00036F;
	localparam logic [CpWidth-1:0] Mark1Lo = 21'h001AB0;
	localparam logic [CpWidth-1:0] Mark1Hi = 21'h001AFF;
	localparam logic [CpWidth-1:0] Mark2Lo = 21'h001DC0;
	localparam logic [CpWidth-1:0] Mark2Hi = 21'h001DFF;
	localparam logic [CpWidth-1:0] Mark3Lo = 21'h0020D0;
	localparam logic [CpWidth-1:0] Mark3Hi = 21'h0020FF;
	localparam logic [CpWidth-1:0] Mark4Lo = 21'h00FE20;
	localparam logic [CpWidth-1:0] Mark4Hi = 21'h00FE2F;
	localparam logic [CpWidth-1:0] SurrLo  = 21'h00D800;
	localparam logic [CpWidth-1:0] SurrHi  = 21'h00DFFF;
	localparam logic [CpWidth-1:0] CpMax   = 21'h10FFFF;
	localparam logic [CpWidth-1:0] Min2    = 21'h000080;
	localparam logic [CpWidth-1:0] Min3    = 21'h000800;
	localparam logic [CpWidth-1:0] Min4    = 21'h010000;

	function automatic logic in_mark(input logic [CpWidth-1:0] cp);
		in_mark = (cp >= Mark0Lo && cp <= Mark0Hi) || (cp >= Mark1Lo && cp <= Mark1Hi)
			|| (cp >= Mark2Lo && cp <= Mark2Hi) || (cp >= Mark3Lo && cp <= Mark3Hi)
			|| (cp >= Mark4Lo && cp <= Mark4Hi);
	endfunction

	function automatic logic rejected(input logic [2:0] len, input logic [CpWidth-1:0] cp);
		logic bad;
		bad = in_mark(cp);
		if (len == 3'd2 && cp < Min2) bad = 1'b1;
		if (len == 3'd3 && (cp < Min3 || (cp >= SurrLo && cp <= SurrHi))) bad = 1'b1;
		if (len == 3'd4 && (cp < Min4 || cp > CpMax)) bad = 1'b1;
		rejected = bad;
	endfunction

	utf8v_state_t upd;

	always_comb begin
		upd = cur;
		if (has_byte && !cur.failed) begin
			if (cur.bytes_left == 2'd0) begin
				unique case (text_byte) inside
					[8'h00:8'h7F]: begin
						upd.seq_length = 3'd0;
						upd.code_point = {13'd0, text_byte};
						if (in_mark(upd.code_point)) upd.failed = 1'b1;
					end
					[8'hC2:8'hDF]: begin
						upd.seq_length = 3'd2;
						upd.bytes_left = 2'd1;
						upd.code_point = {16'd0, text_byte[4:0]};
					end
					[8'hE0:8'hEF]: begin
						upd.seq_length = 3'd3;
						upd.bytes_left = 2'd2;
						upd.code_point = {17'd0, text_byte[3:0]};
					end
					[8'hF0:8'hF4]: begin
						upd.seq_length = 3'd4;
						upd.bytes_left = 2'd3;
						upd.code_point = {18'd0, text_byte[2:0]};
					end
					default: upd.failed = 1'b1;
				endcase
			end else if (text_byte[7:6] != 2'b10) begin
				upd.failed = 1'b1;
			end else begin
				upd.code_point = {cur.code_point[CpWidth-7:0], text_byte[5:0]};
				upd.bytes_left = cur.bytes_left - 2'd1;
				if (upd.bytes_left == 2'd0) begin
					if (rejected(cur.seq_length, upd.code_point)) upd.failed = 1'b1;
					upd.seq_length = 3'd0;
				end
			end
		end
	end

	// The verdict uses the state after this byte; a last item then restarts.
	assign verdict = !upd.failed && (upd.bytes_left == 2'd0);
	assign nxt     = last ? StateReset : upd;

endmodule

// File: design/utf8_validator_no_combining.sv
// ----------------------------------------------------------------------------
// utf8_validator_no_combining: streaming UTF-8 checker without combining marks
// Registers each byte, runs it through the decoder and returns a verdict
// for every string on the transfer marked last.
// ----------------------------------------------------------------------------
// The block takes one byte per transfer on the slave side and sustains one
// transfer per clock while its input is not stalled. Each byte is held in the
// input register, where the decoder works on it, and the decoder state and
// result registers load when it moves on, so a string's verdict reaches the
// master side from the result register, behind the input register. Only
// transfers with tlast high produce a result; tdata bit 0 is 1 when the
// whole string is well-formed UTF-8 that holds no combining mark. An
// end-only transfer (tuser low) closes the string without adding a byte, so
// a lone end-only transfer reports an empty, valid string. Once any error
// is seen the string stays failed until its end. Back-pressure stalls the
// input only when a verdict is waiting in the result register and the next
// registered item also ends a string.
module utf8_validator_no_combining (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] text_byte
	input  logic       s_tuser,  // [0] has_byte
	input  logic       s_tlast,  // last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata   // [0] valid_res, [7:1] zero
);
	import utf8v_pkg::*;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       has_s1;
	logic       last_s1;

	// Decoder state and result register.
	utf8v_state_t state_q;
	utf8v_state_t state_nxt;
	logic         verdict;
	logic         out_valid_q;
	logic         out_res_q;

	// A registered item moves on unless it ends a string while the result
	// register still holds an untaken verdict.
	logic advance;
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			has_s1  <= s_tuser;
			last_s1 <= s_tlast;
		end
	end

	utf8v_step u_step (
		.cur       (state_q),
		.text_byte (byte_s1),
		.has_byte  (has_s1),
		.last      (last_s1),
		.nxt       (state_nxt),
		.verdict   (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StateReset;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_res_q <= verdict;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_res_q};

endmodule

// File: design/utf8v_checker.sv
// ----------------------------------------------------------------------------
// utf8v_checker: port-level checks for the UTF-8 validator
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module utf8v_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// A stalled verdict holds until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("verdict changed or dropped while stalled");

	// The verdict is a single bit; the padding stays zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:1] == 7'd0)
		else $error("padding bits of the verdict are not zero");

	// The input stalls only behind a verdict the master side refuses.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

	// A stall on the input lasts no longer than the output stall behind it.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready && m_tready |=> s_tready)
		else $error("input stayed stalled after the verdict was taken");

endmodule

bind utf8_validator_no_combining utf8v_checker u_utf8v_checker (.*);

// File: tb/tb_utf8_validator_no_combining.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_validator_no_combining: self-checking bench for the UTF-8 checker
// Streams directed and random strings into the validator with random bursts
// and receiver stalls, predicts each string verdict and compares it with the
// verdict transfers that come out of the block.
// ----------------------------------------------------------------------------
module tb_utf8_validator_no_combining;

	import utf8v_pkg::*;

	// Combining-mark ranges that the block rejects, plus the other limits of
	// the code space.
	localparam logic [20:0] MarkALo = 21'h000300, MarkAHi = 21'h00036F;
	localparam logic [20:0] MarkBLo = 21'h001AB0, MarkBHi = 21'h001AFF;
	localparam logic [20:0] MarkCLo = 21'h001DC0, MarkCHi = 21'h001DFF;
	localparam logic [20:0] MarkDLo = 21'h0020D0, MarkDHi = 21'h0020FF;
	localparam logic [20:0] MarkELo = 21'h00FE20, MarkEHi = 21'h00FE2F;
	localparam logic [20:0] SurrLo  = 21'h00D800, SurrHi  = 21'h00DFFF;
	localparam logic [20:0] CpMax   = 21'h10FFFF;

	localparam int unsigned RandomItems = 790;
	localparam int unsigned LongHold    = 64;

	typedef enum int {RxAlways, RxCoin, RxRareStall, RxPeriodic} rx_mode_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       has_byte;
		logic       last;
	} text_item_t;

	// ------------------------------------------------------------------------
	// Verdict scoreboard. It keeps its own decoder state, runs every accepted
	// byte through it and queues one expected verdict per string end.
	// ------------------------------------------------------------------------
	class verdict_board_t;
		utf8v_state_t dec;
		bit           expected_verdicts[$];
		int unsigned  fail_count;

		function new();
			dec = StateReset;
			fail_count = 0;
		endfunction

		function bit in_mark(logic [20:0] cp);
			return (cp >= MarkALo && cp <= MarkAHi) || (cp >= MarkBLo && cp <= MarkBHi)
				|| (cp >= MarkCLo && cp <= MarkCHi) || (cp >= MarkDLo && cp <= MarkDHi)
				|| (cp >= MarkELo && cp <= MarkEHi);
		endfunction

		// Overlong forms, surrogates and values past the top of the code space
		// are rejected by sequence length; marks are rejected at any length.
		function bit cp_rejected(logic [2:0] len, logic [20:0] cp);
			if (len == 3'd2 && cp < 21'h80) return 1'b1;
			if (len == 3'd3 && (cp < 21'h800 || (cp >= SurrLo && cp <= SurrHi))) return 1'b1;
			if (len == 3'd4 && (cp < 21'h10000 || cp > CpMax)) return 1'b1;
			return in_mark(cp);
		endfunction

		function void decode_byte(logic [7:0] c);
			if (dec.failed) return;
			if (dec.bytes_left == 2'd0) begin
				if (c < 8'h80) begin
					dec.seq_length = 3'd0;
					dec.code_point = {13'd0, c};
					if (in_mark(dec.code_point)) dec.failed = 1'b1;
				end else if (c >= 8'hC2 && c <= 8'hDF) begin
					dec.seq_length = 3'd2;
					dec.bytes_left = 2'd1;
					dec.code_point = {16'd0, c[4:0]};
				end else if (c >= 8'hE0 && c <= 8'hEF) begin
					dec.seq_length = 3'd3;
					dec.bytes_left = 2'd2;
					dec.code_point = {17'd0, c[3:0]};
				end else if (c >= 8'hF0 && c <= 8'hF4) begin
					dec.seq_length = 3'd4;
					dec.bytes_left = 2'd3;
					dec.code_point = {18'd0, c[2:0]};
				end else begin
					dec.failed = 1'b1;
				end
				return;
			end
			if (c[7:6] != 2'b10) begin
				dec.failed = 1'b1;
				return;
			end
			dec.code_point = {dec.code_point[14:0], c[5:0]};
			dec.bytes_left = dec.bytes_left - 2'd1;
			if (dec.bytes_left == 2'd0) begin
				if (cp_rejected(dec.seq_length, dec.code_point)) dec.failed = 1'b1;
				dec.seq_length = 3'd0;
			end
		endfunction

		function void note_transfer(logic [7:0] c, logic has_byte, logic last);
			if (has_byte) decode_byte(c);
			if (!last) return;
			expected_verdicts.insert(expected_verdicts.size(),
				!dec.failed && dec.bytes_left == 2'd0);
			dec = StateReset;
		endfunction

		function void check_verdict(logic [7:0] data);
			bit want;
			if (expected_verdicts.size() == 0) begin
				$error("valid_res: expected no transfer, actual %0d", data[0]);
				fail_count++;
				return;
			end
			want = expected_verdicts.pop_front();
			if (data[0] !== want) begin
				$error("valid_res mismatch: expected %0d, actual %0d", want, data[0]);
				fail_count++;
			end
			if (data[7:1] !== 7'd0) begin
				$error("m_tdata[7:1] mismatch: expected 0, actual %0h", data[7:1]);
				fail_count++;
			end
		endfunction

		function int pending();
			return expected_verdicts.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;  // [7:0] text_byte
	logic       s_tuser;  // [0] has_byte
	logic       s_tlast;  // last
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;  // [0] valid_res, [7:1] zero

	verdict_board_t board = new();

	// Stimulus-side controls. The receiver process reads them but only the
	// main stimulus process writes them.
	rx_mode_t    rx_mode = RxAlways;
	int unsigned hold_seq = 0;
	bit          tx_gaps = 1'b1;
	int unsigned burst_left = 0;
	int unsigned random_sent = 0;
	text_item_t  staged_items[$];

	utf8_validator_no_combining u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// Watchdog. The slowest legal run is far below this, so reaching it means
	// the block hung or dropped a verdict.
	initial begin
		#1000000;
		$display("utf8_validator_no_combining regression: fail");
		$finish;
	end

	// Monitor. Both sides are sampled at the rising edge, before the block's
	// registers update, so every transfer is seen with the values it carried.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) board.note_transfer(s_tdata, s_tuser, s_tlast);
			if (m_tvalid && m_tready) board.check_verdict(m_tdata);
		end
	end

	// Receiver. It follows the current stall pattern, and whenever the
	// stimulus bumps hold_seq it holds tready low for a long stretch that it
	// counts on its own.
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned rx_cycle = 0;
	always @(negedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= LongHold - 1;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RxAlways:    m_tready <= 1'b1;
				RxCoin:      m_tready <= 1'($urandom_range(0, 1));
				RxRareStall: m_tready <= ($urandom_range(0, 3) != 0);
				default:     m_tready <= (rx_cycle % 5 < 2);
			endcase
		end
	end

	// Offers one item and holds it until the block takes it. Gaps between
	// bursts drop tvalid and put junk on the data lines.
	task automatic send_item(text_item_t item);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = tx_gaps ? $urandom_range(1, 6) : 0;
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				s_tdata  <= 8'($urandom);
				s_tuser  <= 1'($urandom);
				s_tlast  <= 1'($urandom);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= item.text_byte;
		s_tuser  <= item.has_byte;
		s_tlast  <= item.last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic flush_items();
		foreach (staged_items[i]) begin
			send_item(staged_items[i]);
			random_sent++;
		end
		staged_items.delete();
	endtask

	// The sender withdraws its offer and pauses until every verdict it is
	// owed has come out.
	task automatic wait_verdicts();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	function automatic void stage(logic [7:0] b, logic has_byte, logic last);
		text_item_t item;
		item = '{text_byte: b, has_byte: has_byte, last: last};
		staged_items.insert(staged_items.size(), item);
	endfunction

	// Encodes a code point in the given number of bytes, whether or not that
	// length is the shortest one, so overlong forms come out naturally.
	function automatic void stage_cp(logic [20:0] cp, int len);
		case (len)
			1: stage({1'b0, cp[6:0]}, 1'b1, 1'b0);
			2: begin
				stage({3'b110, cp[10:6]}, 1'b1, 1'b0);
				stage({2'b10, cp[5:0]}, 1'b1, 1'b0);
			end
			3: begin
				stage({4'b1110, cp[15:12]}, 1'b1, 1'b0);
				stage({2'b10, cp[11:6]}, 1'b1, 1'b0);
				stage({2'b10, cp[5:0]}, 1'b1, 1'b0);
			end
			default: begin
				stage({5'b11110, cp[20:18]}, 1'b1, 1'b0);
				stage({2'b10, cp[17:12]}, 1'b1, 1'b0);
				stage({2'b10, cp[11:6]}, 1'b1, 1'b0);
				stage({2'b10, cp[5:0]}, 1'b1, 1'b0);
			end
		endcase
	endfunction

	// Picks a code point and a length, leaning toward the edges of the mark
	// ranges, the surrogates, the overlong limits and the top of the space.
	task automatic pick_cp(output logic [20:0] cp, output int len);
		logic [20:0] lo, hi;
		case ($urandom_range(0, 11))
			3: begin cp = 21'($urandom_range(21'h80, 21'h7FF)); len = 2; end
			4: begin cp = 21'($urandom_range(21'h800, 21'hFFFF)); len = 3; end
			5: begin cp = 21'($urandom_range(21'h10000, CpMax)); len = 4; end
			6: begin
				case ($urandom_range(0, 4))
					0: begin lo = MarkALo; hi = MarkAHi; end
					1: begin lo = MarkBLo; hi = MarkBHi; end
					2: begin lo = MarkCLo; hi = MarkCHi; end
					3: begin lo = MarkDLo; hi = MarkDHi; end
					default: begin lo = MarkELo; hi = MarkEHi; end
				endcase
				case ($urandom_range(0, 4))
					0: cp = lo - 21'd1;
					1: cp = lo;
					2: cp = hi;
					3: cp = hi + 21'd1;
					default: cp = 21'($urandom_range(lo, hi));
				endcase
				len = (cp < 21'h800) ? 2 : 3;
			end
			7: begin
				case ($urandom_range(0, 3))
					0: cp = SurrLo - 21'd1;
					1: cp = SurrLo;
					2: cp = SurrHi;
					default: cp = SurrHi + 21'd1;
				endcase
				len = 3;
			end
			8: begin
				len = $urandom_range(2, 4);
				case (len)
					2: cp = 21'($urandom_range(21'h7E, 21'h81));
					3: cp = 21'($urandom_range(21'h7FE, 21'h801));
					default: cp = 21'($urandom_range(21'hFFFE, 21'h10001));
				endcase
				if ($urandom_range(0, 1)) cp = 21'($urandom_range(0, cp));
			end
			9: begin
				case ($urandom_range(0, 2))
					0: cp = CpMax;
					1: cp = CpMax + 21'd1;
					default: cp = 21'($urandom_range(21'h10000, 21'h1FFFFF));
				endcase
				len = 4;
			end
			default: begin cp = 21'($urandom_range(0, 8'h7F)); len = 1; end
		endcase
	endtask

	// Builds one random string. Most are made of whole encoded code points;
	// the rest are raw noise, cut-off sequences or strings with a stray byte.
	task automatic stage_random_string();
		logic [20:0] cp;
		int          len;
		int          n_cp;
		int          style;
		int          cut;
		n_cp  = $urandom_range(0, 6);
		style = $urandom_range(0, 9);
		if (style == 7) begin
			repeat ($urandom_range(1, 8)) stage(8'($urandom), 1'b1, 1'b0);
		end else begin
			repeat (n_cp) begin
				pick_cp(cp, len);
				stage_cp(cp, len);
				if ($urandom_range(0, 7) == 0) stage(8'($urandom), 1'b0, 1'b0);
				if (style == 9 && $urandom_range(0, 2) == 0) stage(8'($urandom), 1'b1, 1'b0);
			end
			if (style == 8) begin
				pick_cp(cp, len);
				stage_cp(cp, (len < 2) ? 2 : len);
				cut = $urandom_range(1, 3);
				while (cut > 0 && staged_items.size() > 1) begin
					void'(staged_items.pop_back());
					cut--;
				end
			end
		end
		if (staged_items.size() != 0 && $urandom_range(0, 1))
			staged_items[staged_items.size() - 1].last = 1'b1;
		else
			stage(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		int unsigned n_strings;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'd0;
		s_tuser  = 1'b0;
		s_tlast  = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed strings: empty string, the single-byte extremes, bad lead
		// bytes with the failure sticking over later good bytes, a bad
		// continuation, a truncated end with an ignored item inside, the
		// overlong, surrogate, above-range and combining-mark rejects, and
		// the highest legal code point.
		rx_mode = RxCoin;
		stage(8'hA5, 1'b0, 1'b1);
		stage(8'h00, 1'b1, 1'b0); stage(8'h7F, 1'b1, 1'b1);
		stage(8'hFF, 1'b1, 1'b0); stage(8'h41, 1'b1, 1'b1);
		stage(8'hC1, 1'b1, 1'b1);
		stage(8'hE0, 1'b1, 1'b0); stage(8'h41, 1'b1, 1'b1);
		stage(8'hC3, 1'b1, 1'b0); stage(8'h5A, 1'b0, 1'b0); stage(8'hFF, 1'b0, 1'b1);
		stage_cp(21'h00007F, 2); staged_items[staged_items.size() - 1].last = 1'b1;
		stage_cp(21'h00D800, 3); staged_items[staged_items.size() - 1].last = 1'b1;
		stage_cp(21'h110000, 4); staged_items[staged_items.size() - 1].last = 1'b1;
		stage_cp(MarkALo, 2);    staged_items[staged_items.size() - 1].last = 1'b1;
		stage_cp(CpMax, 4);      staged_items[staged_items.size() - 1].last = 1'b1;
		flush_items();
		wait_verdicts();

		// Back-pressure: the receiver holds off while the sender keeps
		// offering short strings back to back, so verdicts pile up and the
		// block has to stall its input.
		tx_gaps = 1'b0;
		rx_mode = RxAlways;
		hold_seq = hold_seq + 1;
		repeat (30) begin
			if ($urandom_range(0, 1)) stage(8'($urandom), 1'b0, 1'b1);
			else stage(8'($urandom_range(0, 8'h7F)), 1'b1, 1'b1);
		end
		flush_items();
		wait_verdicts();

		// Random strings in phases, each with its own stall pattern and with
		// or without sender gaps.
		random_sent = 0;
		n_strings = 0;
		while (random_sent < RandomItems) begin
			if (n_strings % 40 == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				tx_gaps = ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 2) == 0) wait_verdicts();
			end
			stage_random_string();
			flush_items();
			n_strings++;
		end

		rx_mode = RxCoin;
		wait_verdicts();
		repeat (8) @(posedge clk);
		if (board.fail_count == 0)
			$display("utf8_validator_no_combining regression: pass");
		else
			$display("utf8_validator_no_combining regression: fail");
		$finish;
	end

endmodule

// File: utf8_validator_no_combining.f
design/utf8v_pkg.sv
design/utf8v_step.sv
design/utf8_validator_no_combining.sv
design/utf8v_checker.sv
tb/tb_utf8_validator_no_combining.sv
